@@ sv/delta_varlen_sample_packer_assert.svh @@
// Assertion macros for the delta sample packer.
// Depends on clk_i and rst_ni being visible in the module that includes it.
`ifndef DELTA_VARLEN_SAMPLE_PACKER_ASSERT_SVH
`define DELTA_VARLEN_SAMPLE_PACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define DVSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define DVSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/dvsp_pkg.sv @@
// Shared types, constants and helpers for the delta sample packer.
// No dependencies; imported by dvsp_core and delta_varlen_sample_packer.
package dvsp_pkg;

  // Capacity of the data byte area and of the size-code headers
  localparam int unsigned DataBytes  = 64;
  localparam int unsigned MaxEntries = 64;
  localparam int unsigned CntW       = 7;
  localparam int unsigned SumW       = CntW + 1;

  localparam logic [31:0] SkipMarker = 32'h8000_0000;

  // Input command codes
  localparam logic CmdPack  = 1'b0;
  localparam logic CmdFlush = 1'b1;

  // Packed widths on the stream ports
  localparam int unsigned OutDataW = 64;
  localparam int unsigned OutUserW = 3;

  typedef struct packed {
    logic [31:0]     prev_sample;
    logic [CntW-1:0] data_bytes;
    logic [CntW-1:0] entries;
    logic [7:0]      header_acc;
  } state_t;

  typedef struct packed {
    logic [31:0]     delta_word;
    logic [2:0]      byte_count;
    logic [1:0]      len_code;
    logic [3:0]      header_index;
    logic [7:0]      header_byte;
    logic [6:0]      packed_size;
    logic [CntW-1:0] entries;
    logic            skipped;
    logic            overflow;
    logic            flushed;
  } result_t;

  // Fewest bytes that hold a delta as a two's complement value
  function automatic logic [2:0] bytes_needed(input logic [31:0] d);
    logic [2:0] n;
    if (d[31:7] == '0 || d[31:7] == '1) begin
      n = 3'd1;
    end else if (d[31:15] == '0 || d[31:15] == '1) begin
      n = 3'd2;
    end else if (d[31:23] == '0 || d[31:23] == '1) begin
      n = 3'd3;
    end else begin
      n = 3'd4;
    end
    return n;
  endfunction

endpackage

@@ sv/dvsp_core.sv @@
// Per-request encode logic: delta, length code, header byte, totals and next state.
// Depends on dvsp_pkg.
module dvsp_core
  import dvsp_pkg::*;
(
  input  logic    cmd_i,
  input  logic [31:0] sample_i,
  input  state_t  st_i,
  output result_t res_o,
  output state_t  st_o
);

  logic [31:0]     delta;
  logic [2:0]      len;
  logic [SumW-1:0] byte_sum;
  logic            full;
  logic [1:0]      code;
  logic [7:0]      hdr_base;
  logic [7:0]      hdr_new;
  logic [4:0]      old_headers;
  logic [6:0]      size_now;
  logic [6:0]      size_after;

  // Delta against the last packed sample and its byte length
  assign delta    = sample_i - st_i.prev_sample;
  assign len      = bytes_needed(delta);
  assign code     = len[1:0] - 2'd1;
  assign byte_sum = {1'b0, st_i.data_bytes} + {{(SumW-3){1'b0}}, len};
  assign full     = (st_i.entries >= CntW'(MaxEntries)) || (byte_sum > SumW'(DataBytes));

  // Start a fresh header byte on every fourth code, else OR into the current one
  assign hdr_base = (st_i.entries[1:0] == 2'd0) ? 8'h00 : st_i.header_acc;
  assign hdr_new  = hdr_base | ({6'b0, code} << {st_i.entries[1:0], 1'b0});

  // Running packed size before and after this entry
  assign old_headers = st_i.entries[6:2];
  assign size_now    = st_i.data_bytes + {2'b0, old_headers} + 7'd2;
  assign size_after  = byte_sum[6:0] + {2'b0, old_headers} + 7'd2;

  always_comb begin
    res_o = '0;
    st_o  = st_i;
    res_o.packed_size = size_now;
    res_o.entries     = st_i.entries;
    if (cmd_i == CmdFlush) begin
      // Report totals, then clear everything
      res_o.flushed = 1'b1;
      st_o          = '0;
    end else if (sample_i == SkipMarker) begin
      res_o.skipped = 1'b1;
    end else if (full) begin
      res_o.overflow = 1'b1;
    end else begin
      // Accept the sample and advance the totals
      res_o.delta_word   = delta;
      res_o.byte_count   = len;
      res_o.len_code     = code;
      res_o.header_index = st_i.entries[5:2];
      res_o.header_byte  = hdr_new;
      res_o.packed_size  = size_after;
      res_o.entries      = st_i.entries + 7'd1;
      st_o.prev_sample   = sample_i;
      st_o.data_bytes    = byte_sum[CntW-1:0];
      st_o.entries       = st_i.entries + 7'd1;
      st_o.header_acc    = hdr_new;
    end
  end

endmodule

@@ sv/delta_varlen_sample_packer.sv @@
// Top level of the delta sample packer: input stage, state and result register.
// Depends on dvsp_pkg, dvsp_core and delta_varlen_sample_packer_assert.svh.
//
// Usage:
//   The slave channel takes one request per cycle while tready is high:
//   tuser[0] is the command (0 = pack the sample in tdata, 1 = flush) and
//   tdata[31:0] the sample. The master channel returns
//   exactly one result per request, in order. A request accepted into the
//   input stage moves on to the result register, which drives the master
//   side, once that is free. The subtract, the length check and the header
//   OR all sit between the two; the packer state updates as a request moves.
//   Stall: while the result register holds an untaken result, the input
//   stage still accepts one more request; tready drops only when both the
//   input stage and the result register are occupied and the receiver holds
//   tready low.
//   Reset: all valid flags and the packer state (previous sample, byte and
//   entry totals, header byte) return to zero; no clearing pass is needed.
//   A flush reports the totals and then returns the state to reset values.
module delta_varlen_sample_packer
  import dvsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: [31:0] sample
  input  logic [31:0]         s_axis_tdata,
  // tuser: [0] cmd
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: [31:0] delta_word, [34:32] byte_count, [36:35] len_code,
  //        [40:37] header_index, [48:41] header_byte, [55:49] packed_size,
  //        [62:56] entries, [63] zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: [0] skipped, [1] overflow, [2] flushed
  output logic [OutUserW-1:0] m_axis_tuser
);

  logic                in_vld_q;
  logic                in_cmd_q;
  logic [31:0]         in_sample_q;
  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;
  state_t              st_q;
  state_t              st_d;
  result_t             res;
  logic                advance;
  logic                in_take;
  logic                bytes_ok;
  logic                entries_ok;
  logic                out_flagged;
  logic                flag_clean;
  logic                flush_adv;
  logic                st_clear;

  // Move the held request into the result register when it is free
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  dvsp_core u_core (
    .cmd_i    (in_cmd_q),
    .sample_i (in_sample_q),
    .st_i     (st_q),
    .res_o    (res),
    .st_o     (st_d)
  );

  // Input stage valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q    <= s_axis_tuser;
      in_sample_q <= s_axis_tdata;
    end
  end

  // Packer state, updated as each request advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {1'b0, res.entries, res.packed_size, res.header_byte,
                     res.header_index, res.len_code, res.byte_count, res.delta_word};
      out_user_q <= {res.flushed, res.overflow, res.skipped};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // Terms checked by the assertions below
  assign bytes_ok    = st_q.data_bytes <= CntW'(DataBytes);
  assign entries_ok  = st_q.entries <= CntW'(MaxEntries);
  assign out_flagged = m_axis_tvalid && (m_axis_tuser != '0);
  assign flag_clean  = $onehot0(m_axis_tuser) && (m_axis_tdata[34:32] == 3'd0);
  assign flush_adv   = advance && (in_cmd_q == CmdFlush);
  assign st_clear    = (st_q == '0);

`include "delta_varlen_sample_packer_assert.svh"

  `DVSP_ASSERT_NOW(a_bytes_cap, 1'b1, bytes_ok, "data byte total above capacity")
  `DVSP_ASSERT_NOW(a_entry_cap, 1'b1, entries_ok, "entry total above header capacity")
  `DVSP_ASSERT_NOW(a_flag_bytes, out_flagged, flag_clean, "flagged result carries delta bytes")
  `DVSP_ASSERT_NEXT(a_flush_clear, flush_adv, st_clear, "state not cleared after flush")

endmodule

@@ bench/delta_varlen_sample_packer_tb.sv @@
// Self-checking bench for delta_varlen_sample_packer: directed corner requests,
// then random sample runs, predicted in a scoreboard class; depends on dvsp_pkg.
`timescale 1ns / 100ps

module delta_varlen_sample_packer_tb;
  import dvsp_pkg::*;

  localparam int unsigned RandomRequests = 1150;

  // Predicts each packed result and checks results in order
  class delta_pack_checker;
    logic [31:0] prev_sample;
    int unsigned data_bytes;
    int unsigned entry_cnt;
    logic [7:0]  header_acc;
    result_t     pending_results[$];
    int unsigned errors;
    int unsigned reported;
    int unsigned result_cnt;

    function new();
      clear_state();
      errors     = 0;
      reported   = 0;
      result_cnt = 0;
    endfunction

    function void clear_state();
      prev_sample = '0;
      data_bytes  = 0;
      entry_cnt   = 0;
      header_acc  = '0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function logic [6:0] size_now();
      return 7'(data_bytes + entry_cnt / 4 + 2);
    endfunction

    // Fewest bytes that hold a delta in two's complement
    function int unsigned span_bytes(logic signed [31:0] d);
      if (d >= -128 && d <= 127) return 1;
      if (d >= -32768 && d <= 32767) return 2;
      if (d >= -8388608 && d <= 8388607) return 3;
      return 4;
    endfunction

    // Work out the result of one accepted request and advance the state
    function void accept_request(logic cmd, logic [31:0] sample);
      result_t     r;
      logic [31:0] d;
      int unsigned len;
      int unsigned slot;
      int unsigned hdrs;
      r = '0;
      if (cmd == CmdFlush) begin
        r.flushed     = 1'b1;
        r.packed_size = size_now();
        r.entries     = 7'(entry_cnt);
        clear_state();
      end else if (sample == SkipMarker) begin
        r.skipped     = 1'b1;
        r.packed_size = size_now();
        r.entries     = 7'(entry_cnt);
      end else begin
        d   = sample - prev_sample;
        len = span_bytes(d);
        if (entry_cnt >= MaxEntries || data_bytes + len > DataBytes) begin
          // refused: report like a skip, state untouched
          r.overflow    = 1'b1;
          r.packed_size = size_now();
          r.entries     = 7'(entry_cnt);
        end else begin
          slot = entry_cnt % 4;
          hdrs = entry_cnt / 4;
          // first code of a header byte starts it fresh
          if (slot == 0) begin
            header_acc = '0;
          end
          header_acc = header_acc | (8'(len - 1) << (2 * slot));
          r.delta_word   = d;
          r.byte_count   = 3'(len);
          r.len_code     = 2'(len - 1);
          r.header_index = 4'(hdrs);
          r.header_byte  = header_acc;
          data_bytes  += len;
          entry_cnt   += 1;
          prev_sample  = sample;
          r.packed_size = 7'(data_bytes + hdrs + 2);
          r.entries     = 7'(entry_cnt);
        end
      end
      pending_results.push_back(r);
    endfunction

    function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
      if (want === got) return 1'b0;
      if (reported < 10) begin
        $display("result %0d: %s expected 'h%0h, got 'h%0h", result_cnt, name, want, got);
      end
      reported++;
      return 1'b1;
    endfunction

    // Compare one taken result with the oldest prediction
    function void check_result(logic [OutDataW-1:0] tdata, logic [OutUserW-1:0] tuser);
      result_t want;
      bit      bad;
      result_cnt++;
      if (pending_results.size() == 0) begin
        if (reported < 10) begin
          $display("result %0d: unexpected, tdata 'h%0h tuser 'h%0h",
                   result_cnt, tdata, tuser);
        end
        reported++;
        errors++;
        return;
      end
      want = pending_results.pop_front();
      bad  = 1'b0;
      bad |= field_differs("delta_word",   want.delta_word,   tdata[31:0]);
      bad |= field_differs("byte_count",   want.byte_count,   tdata[34:32]);
      bad |= field_differs("len_code",     want.len_code,     tdata[36:35]);
      bad |= field_differs("header_index", want.header_index, tdata[40:37]);
      bad |= field_differs("header_byte",  want.header_byte,  tdata[48:41]);
      bad |= field_differs("packed_size",  want.packed_size,  tdata[55:49]);
      bad |= field_differs("entries",      want.entries,      tdata[62:56]);
      bad |= field_differs("skipped",      want.skipped,      tuser[0]);
      bad |= field_differs("overflow",     want.overflow,     tuser[1]);
      bad |= field_differs("flushed",      want.flushed,      tuser[2]);
      if (bad) begin
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  bit                  no_idle = 1'b0;
  int unsigned         sent_cnt = 0;
  delta_pack_checker   sb = new();

  delta_varlen_sample_packer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Stall the result side at random, except in the quiet stretch
  always @(negedge clk_i) begin
    m_axis_tready <= no_idle || ($urandom_range(99) >= 33);
  end

  // Note accepted requests and check taken results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.accept_request(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser);
      end
    end
  end

  // Present one request from a falling edge until it is taken
  task automatic send_request(input logic cmd, input logic [31:0] sample);
    while (!no_idle && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= $urandom;
      s_axis_tuser  <= 1'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Random runs of samples, each closed by a flush
  task automatic run_random();
    logic [31:0]        walk;
    logic signed [31:0] step;
    int unsigned        run_len;
    int unsigned        mode;
    int unsigned        roll;
    int unsigned        shift;
    int unsigned        start_cnt;
    start_cnt = sent_cnt;
    while (sent_cnt - start_cnt < RandomRequests) begin
      no_idle = (sent_cnt - start_cnt >= 450) && (sent_cnt - start_cnt < 600);
      walk    = '0;
      mode    = $urandom_range(3);
      run_len = $urandom_range(5, 80);
      for (int unsigned i = 0; i < run_len; i++) begin
        roll = $urandom_range(99);
        if (roll < 4) begin
          send_request(CmdPack, SkipMarker);
        end else if (roll < 7) begin
          // flush in the middle of a run
          send_request(CmdFlush, $urandom);
          walk = '0;
        end else if (roll < 10) begin
          walk = $urandom;
          send_request(CmdPack, walk);
        end else begin
          // mode 0 keeps the random steps to one-byte deltas to reach the entry limit
          shift = (mode == 0) ? 24 : 8 * $urandom_range(3);
          step  = $signed($urandom) >>> shift;
          walk  = walk + step;
          send_request(CmdPack, walk);
        end
      end
      send_request(CmdFlush, $urandom);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Size boundaries, skip marker and flush on an empty packer
    send_request(CmdFlush, 32'h0000_0000);
    send_request(CmdPack,  32'h0000_0000);
    send_request(CmdPack,  32'h0000_007F);
    send_request(CmdPack,  32'h0000_00FF);
    send_request(CmdPack,  32'h0000_007F);
    send_request(CmdPack,  32'hFFFF_FFFE);
    send_request(CmdPack,  SkipMarker);
    send_request(CmdPack,  32'h0000_7FFD);
    send_request(CmdPack,  32'h0000_FFFD);
    send_request(CmdPack,  32'h0000_7FFC);
    send_request(CmdPack,  32'h0100_7FFB);
    send_request(CmdPack,  32'h7FFF_FFFF);
    send_request(CmdPack,  32'h8000_0001);
    // Fill the data area with four-byte deltas; the last one is refused
    for (int k = 0; k < 11; k++) begin
      send_request(CmdPack, k[0] ? 32'h7FFF_FFFF : 32'h0000_0000);
    end
    send_request(CmdFlush, 32'hFFFF_FFFF);

    run_random();
    s_axis_tvalid <= 1'b0;

    // Drain, then allow a few more cycles for stray results
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Hard stop if the run hangs
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
